[design/sbmq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants of the shared multi-queue sample buffer.
// ----------------------------------------------------------------------------
package sbmq_pkg;

	localparam int NODE_ID_W = 4;
	localparam int VALUE_W   = 32;
	localparam int RAND_W    = 16;
	localparam int POLICY_W  = 2;
	localparam int CAP_W     = 11;
	localparam int THR_W     = 6;
	localparam int FILL_W    = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd0;
	localparam logic [POLICY_W-1:0] POL_OLDEST = 2'd1;
	localparam logic [POLICY_W-1:0] POL_NEWEST = 2'd2;
	localparam logic [POLICY_W-1:0] POL_OFF    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [POLICY_W-1:0] POLICY_RST    = POL_RANDOM;
	localparam logic [CAP_W-1:0]    CAPACITY_RST  = 11'd256;
	localparam logic [THR_W-1:0]    THRESHOLD_RST = 6'd5;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic latch;
		logic qlen_rd_node;
		logic append;
		logic div_start_q;
		logic scan_init;
		logic scan_step;
		logic pos_fixed;
		logic div_start_e;
		logic pos_div;
		logic store_rd_pos;
		logic take_dval;
		logic shift_rd;
		logic shift_wr;
		logic finish;
		logic load_out;
	} sbmq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_range;
		logic is_full;
		logic pressure;
		logic div_done;
		logic scan_hit;
		logic pol_random;
		logic shift_more;
		logic out_free;
	} sbmq_sts_t;

endpackage
`default_nettype wire

[design/sbmq_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_in_if
// Request channel carrying one arriving sample.
// ----------------------------------------------------------------------------
interface sbmq_in_if
	import sbmq_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [NODE_ID_W-1:0] node_id;
	logic [VALUE_W-1:0]   sample_value;
	logic [RAND_W-1:0]    pick_queue_random;
	logic [RAND_W-1:0]    pick_entry_random;

	modport source (output valid, node_id, sample_value, pick_queue_random,
		pick_entry_random, input ready);
	modport sink (input valid, node_id, sample_value, pick_queue_random,
		pick_entry_random, output ready);
endinterface
`default_nettype wire

[design/sbmq_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_out_if
// Result channel carrying one result request per sample.
// ----------------------------------------------------------------------------
interface sbmq_out_if
	import sbmq_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic                      drop_happened;
	logic [NODE_ID_W-1:0]      dropped_node;
	logic signed [VALUE_W-1:0] dropped_value;
	logic [FILL_W-1:0]         fill_count;
	logic                      queue_full;

	modport source (output valid, drop_happened, dropped_node, dropped_value,
		fill_count, queue_full, input ready);
	modport sink (input valid, drop_happened, dropped_node, dropped_value,
		fill_count, queue_full, output ready);
endinterface
`default_nettype wire

[design/sbmq_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbmq_div
	import sbmq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAND_W-1:0] dividend,
	input  wire logic [RAND_W-1:0] divisor,
	output logic                   done,
	output logic [RAND_W-1:0]      rem
);
	localparam int CNT_W = $clog2(RAND_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] quo_q;
	logic [RAND_W-1:0] den_q;
	logic [RAND_W-1:0] rem_q;
	logic [RAND_W:0]   trial;

	assign trial = {rem_q, quo_q[RAND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(RAND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[RAND_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= RAND_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[RAND_W-1:0];
			end
		end
	end

	assign done = (cnt_q == '0);
	assign rem  = rem_q;
endmodule
`default_nettype wire

[design/sbmq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer: append, pressure check, victim search, removal and gap closing.
// ----------------------------------------------------------------------------
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire sbmq_sts_t sts,
	output sbmq_cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_LEN, S_CHK, S_DIVQ, S_SCAN, S_PLEN, S_DIVE,
		S_RD, S_RDW, S_SH, S_SHW, S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = 1'b1;
				if (in_valid) begin
					cmd.latch        = 1'b1;
					cmd.qlen_rd_node = 1'b1;
					state_d          = S_LEN;
				end
			end
			S_LEN: begin
				if (!sts.in_range || sts.is_full) begin
					state_d = S_OUT;
				end else begin
					cmd.append = 1'b1;
					state_d    = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.pressure) begin
					cmd.div_start_q = 1'b1;
					state_d         = S_DIVQ;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIVQ: begin
				if (sts.div_done) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) begin
					state_d = S_PLEN;
				end
			end
			S_PLEN: begin
				if (sts.pol_random) begin
					cmd.div_start_e = 1'b1;
					state_d         = S_DIVE;
				end else begin
					cmd.pos_fixed = 1'b1;
					state_d       = S_RD;
				end
			end
			S_DIVE: begin
				if (sts.div_done) begin
					cmd.pos_div = 1'b1;
					state_d     = S_RD;
				end
			end
			S_RD: begin
				cmd.store_rd_pos = 1'b1;
				state_d          = S_RDW;
			end
			S_RDW: begin
				cmd.take_dval = 1'b1;
				state_d       = S_SH;
			end
			S_SH: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d      = S_SHW;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_SHW: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SH;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

[design/sbmq_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_dp
// Datapath: sample store, queue lengths, counters, registers and result.
// ----------------------------------------------------------------------------
module sbmq_dp
	import sbmq_pkg::*;
#(
	parameter int MAX_NODES  = 16,
	parameter int NODE_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sbmq_cmd_t            cmd,
	output sbmq_sts_t                 sts,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	sbmq_in_if.sink                   samples,
	sbmq_out_if.source                results
);
	localparam int NIDX_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int LEN_W  = $clog2(NODE_DEPTH + 1);
	localparam int SLOTS  = MAX_NODES * NODE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int TOT_R  = $clog2(SLOTS + 1);
	localparam int TOT_W  = (TOT_R > FILL_W) ? TOT_R : FILL_W;
	localparam int FREE_W = TOT_W + 2;

	// configuration
	logic [POLICY_W-1:0] policy_q;
	logic [CAP_W-1:0]    cap_q;
	logic [THR_W-1:0]    thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_RST;
			cap_q    <= CAPACITY_RST;
			thr_q    <= THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_POLICY:    policy_q <= cfg_data[POLICY_W-1:0];
				REG_CAPACITY:  cap_q    <= cfg_data[CAP_W-1:0];
				REG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// latched request
	logic [NODE_ID_W-1:0] node_q;
	logic [VALUE_W-1:0]   value_q;
	logic [RAND_W-1:0]    rq_q;
	logic [RAND_W-1:0]    re_q;
	logic [NIDX_W-1:0]    nidx;
	logic [NIDX_W-1:0]    in_nidx;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			node_q  <= samples.node_id;
			value_q <= samples.sample_value;
			rq_q    <= samples.pick_queue_random;
			re_q    <= samples.pick_entry_random;
		end
	end

	assign nidx    = NIDX_W'(node_q);
	assign in_nidx = NIDX_W'(samples.node_id);

	// queue lengths: memory with valid bits, registered read
	logic [LEN_W-1:0]     qlen_mem [MAX_NODES];
	logic [MAX_NODES-1:0] qlen_vld_q;
	logic [LEN_W-1:0]     qlen_rd_q;
	logic [NIDX_W-1:0]    qlen_ra;
	logic [NIDX_W-1:0]    qlen_wa;
	logic [LEN_W-1:0]     qlen_wd;
	logic                 qlen_we;

	// victim search
	logic [MAX_NODES-1:0] nz_q;
	logic [CNT_W-1:0]     nz_cnt_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     seen_q;
	logic [NIDX_W-1:0]    scan_q;
	logic [NIDX_W-1:0]    pick_q;
	logic [LEN_W-1:0]     plen_q;
	logic [LEN_W-1:0]     pos_q;
	logic [LEN_W-1:0]     idx_q;
	logic [TOT_W-1:0]     total_q;
	logic                 drop_q;
	logic [VALUE_W-1:0]   dval_q;
	logic                 hit;

	assign hit     = nz_q[scan_q] && (seen_q == k_q);
	assign qlen_ra = cmd.qlen_rd_node ? in_nidx : scan_q;
	assign qlen_we = cmd.append || cmd.finish;
	assign qlen_wa = cmd.append ? nidx : pick_q;
	assign qlen_wd = cmd.append ? LEN_W'(qlen_rd_q + 1'b1) : LEN_W'(plen_q - 1'b1);

	always_ff @(posedge clk) begin
		if (qlen_we) begin
			qlen_mem[qlen_wa] <= qlen_wd;
		end
		if (cmd.qlen_rd_node || (cmd.scan_step && hit)) begin
			qlen_rd_q <= qlen_vld_q[qlen_ra] ? qlen_mem[qlen_ra] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_vld_q <= '0;
			nz_q       <= '0;
			nz_cnt_q   <= '0;
			total_q    <= '0;
			drop_q     <= 1'b0;
		end else begin
			if (cmd.latch) begin
				drop_q <= 1'b0;
			end
			if (cmd.append) begin
				qlen_vld_q[nidx] <= 1'b1;
				nz_q[nidx]       <= 1'b1;
				total_q          <= total_q + 1'b1;
				if (qlen_rd_q == '0) begin
					nz_cnt_q <= nz_cnt_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				total_q <= total_q - 1'b1;
				drop_q  <= 1'b1;
				if (plen_q == LEN_W'(1)) begin
					nz_q[pick_q] <= 1'b0;
					nz_cnt_q     <= nz_cnt_q - 1'b1;
				end
			end
		end
	end

	// shared remainder unit
	logic              div_start;
	logic [RAND_W-1:0] div_dividend;
	logic [RAND_W-1:0] div_divisor;
	logic              div_done;
	logic [RAND_W-1:0] div_rem;

	assign div_start    = cmd.div_start_q || cmd.div_start_e;
	assign div_dividend = cmd.div_start_q ? rq_q : re_q;
	assign div_divisor  = cmd.div_start_q ? RAND_W'(nz_cnt_q) : RAND_W'(qlen_rd_q);

	sbmq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.rem      (div_rem)
	);

	// sample store: one write and one read port
	logic [VALUE_W-1:0] store_mem [SLOTS];
	logic [VALUE_W-1:0] st_rd_q;
	logic [ADDR_W-1:0]  st_wa;
	logic [ADDR_W-1:0]  st_ra;
	logic [VALUE_W-1:0] st_wd;
	logic               st_we;
	logic               st_re;
	logic [LEN_W-1:0]   rd_off;

	assign st_we  = cmd.append || cmd.shift_wr;
	assign st_wa  = cmd.append ? ADDR_W'(32'(nidx) * NODE_DEPTH + 32'(qlen_rd_q))
	                           : ADDR_W'(32'(pick_q) * NODE_DEPTH + 32'(idx_q));
	assign st_wd  = cmd.append ? value_q : st_rd_q;
	assign st_re  = cmd.store_rd_pos || cmd.shift_rd;
	assign rd_off = cmd.store_rd_pos ? pos_q : LEN_W'(idx_q + 1'b1);
	assign st_ra  = ADDR_W'(32'(pick_q) * NODE_DEPTH + 32'(rd_off));

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= st_wd;
		end
		if (st_re) begin
			st_rd_q <= store_mem[st_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			k_q    <= div_rem[CNT_W-1:0];
			seen_q <= '0;
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			if (hit) begin
				pick_q <= scan_q;
			end else begin
				if (nz_q[scan_q]) begin
					seen_q <= seen_q + 1'b1;
				end
				scan_q <= scan_q + 1'b1;
			end
		end
		if (cmd.pos_fixed || cmd.div_start_e) begin
			plen_q <= qlen_rd_q;
		end
		if (cmd.pos_fixed) begin
			pos_q <= (policy_q == POL_OLDEST) ? '0 : LEN_W'(qlen_rd_q - 1'b1);
		end else if (cmd.pos_div) begin
			pos_q <= div_rem[LEN_W-1:0];
		end
		if (cmd.take_dval) begin
			idx_q <= pos_q;
		end else if (cmd.shift_wr) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.take_dval) begin
			dval_q <= st_rd_q;
		end
	end

	// pressure check on the count after the append
	logic signed [FREE_W-1:0] free_slots;
	assign free_slots = $signed(FREE_W'(cap_q)) - $signed(FREE_W'(total_q));

	assign sts.in_range   = (32'(node_q) < MAX_NODES);
	assign sts.is_full    = (qlen_rd_q >= LEN_W'(NODE_DEPTH));
	assign sts.pressure   = (free_slots <= $signed(FREE_W'(thr_q)))
	                        && (policy_q != POL_OFF);
	assign sts.div_done   = div_done;
	assign sts.scan_hit   = hit;
	assign sts.pol_random = (policy_q == POL_RANDOM);
	assign sts.shift_more = (LEN_W'(idx_q + 1'b1) < plen_q);
	assign sts.out_free   = !results.valid || results.ready;

	// result register
	logic                      out_vld_q;
	logic                      out_drop_q;
	logic [NODE_ID_W-1:0]      out_node_q;
	logic [VALUE_W-1:0]        out_val_q;
	logic [FILL_W-1:0]         out_fill_q;
	logic                      out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// after a drop the length register holds the victim's length, not the arrival's
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_drop_q <= drop_q;
			out_node_q <= drop_q ? NODE_ID_W'(pick_q) : '0;
			out_val_q  <= drop_q ? dval_q : '0;
			out_fill_q <= total_q[FILL_W-1:0];
			out_full_q <= sts.in_range && sts.is_full && !drop_q;
		end
	end

	assign samples.ready         = cmd.accept;
	assign results.valid         = out_vld_q;
	assign results.drop_happened = out_drop_q;
	assign results.dropped_node  = out_node_q;
	assign results.dropped_value = $signed(out_val_q);
	assign results.fill_count    = out_fill_q;
	assign results.queue_full    = out_full_q;
endmodule
`default_nettype wire

[design/shared_buffer_multi_queue_dropper_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_dropper_top
// Shared sample buffer with one queue per node and drop-on-pressure.
// ----------------------------------------------------------------------------
// Sequence: without a drop a request passes the length read, the pressure check
//   and the result; a rejected request skips the check. A drop adds the queue pick
//   remainder, node scan, entry remainder (random only), victim read and shifts.
// Throughput: one request at a time; the next is taken the cycle after the
//   result is loaded.
// Reset: registers to their defaults, all queues empty; store contents stay
//   as they are and are never read before being written.
module shared_buffer_multi_queue_dropper_top
	import sbmq_pkg::*;
#(
	parameter int MAX_NODES  = 16,
	parameter int NODE_DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sbmq_in_if.sink                   samples,
	sbmq_out_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	sbmq_cmd_t cmd;
	sbmq_sts_t sts;
	logic      ctrl_ready;

	sbmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (ctrl_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbmq_dp #(
		.MAX_NODES  (MAX_NODES),
		.NODE_DEPTH (NODE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.samples  (samples),
		.results  (results)
	);

	// a rejected sample never drops anything
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.queue_full |-> !results.drop_happened)
		else $error("drop reported together with a full queue");

	// without a drop the victim fields are cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.drop_happened |->
		(results.dropped_node == '0) && (results.dropped_value == '0))
		else $error("victim fields set without a drop");

	// one request in flight: no new request right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("second request taken while one is in flight");

	// ready follows the controller
	assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready == ctrl_ready)
		else $error("request ready not driven by the controller");
endmodule
`default_nettype wire
